[sv/signed_int_to_radix_ascii_unit_assert.svh]
// Assertion macros used by the port-level checker of the radix text converter.
`ifndef SIGNED_INT_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/sia_pkg.sv]
// Package of types, constants and helper functions for the radix text converter.
package sia_pkg;

    localparam int VALUE_W        = 32;
    localparam int RADIX_W        = 6;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int SIA_MAX_DIGITS = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 8'd87;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_Z  = 8'h7a;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 8'h2d;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } sia_state_t;

    // Clamp the programmed radix into the supported range.
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Map a digit value to its ASCII code: 0..9 to digits, 10..35 to lowercase letters.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d >= DIGIT_TEN)
        begin
            res = CHAR_W'(d) + LETTER_OFFSET;
        end
        else
        begin
            res = CHAR_W'(d) + CHAR_ZERO;
        end
        return res;
    endfunction

endpackage

[sv/signed_int_to_radix_ascii_unit.sv]
// Signed 32-bit integer to ASCII text converter in a programmable radix.
//
// Input stream s_axis: one beat carries one signed 32-bit value in tdata.
// Output stream m_axis: one beat per character, most significant first,
// with a leading '-' for negative values; tlast marks the final digit.
// Config channel cfg: a beat on cfg_valid/cfg_ready writes the radix
// (values below 2 act as 2, above 36 as 36). Write it only while idle.
// Digits come from a bit-serial divider that produces one quotient bit per
// cycle; after each divide the remainder is pushed and the divider restarts
// on the quotient. Once the last digit is pushed, characters follow at one
// character per cycle while the receiver keeps tready high.
// s_axis_tready is high only between values.
// One output register separates the block from the receiver: when tready
// is low the current beat holds and character generation pauses.
// Reset sets the radix to ten and returns the block to idle with no
// output beat pending.
module signed_int_to_radix_ascii_unit
    import sia_pkg::*;
#(
    parameter int MAX_DIGITS = SIA_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] character
    output logic               m_axis_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data        // [5:0] radix
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    sia_state_t          state_reg;
    sia_state_t          state_next;
    logic [RADIX_W-1:0]  radix_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W-1:0]    cnt_inc;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_last_reg;

    logic                slot_free;
    logic                more_digits;
    logic                in_ready;
    logic                div_start;
    logic [VALUE_W-1:0]  div_dividend;
    logic [RADIX_W-1:0]  div_divisor;
    logic                div_done;
    logic [VALUE_W-1:0]  div_quot;
    logic [DIGIT_W-1:0]  div_rem;
    logic                push;
    logic                pop;
    logic [DIGIT_W-1:0]  top_digit;
    logic                load_out;
    logic [CHAR_W-1:0]   load_char;
    logic                load_last;
    logic [VALUE_W-1:0]  magnitude;

    assign slot_free   = !out_valid_reg || m_axis_tready;
    assign cnt_inc     = cnt_reg + CNT_W'(1);
    assign more_digits = (div_quot != '0) && (cnt_inc < CNT_W'(MAX_DIGITS));
    assign div_divisor = effective_radix(radix_reg);
    assign magnitude   = s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + VALUE_W'(1)) : s_axis_tdata;

    sia_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    sia_digit_stack #(
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .clk        (clk),
        .push       (push),
        .pop        (pop),
        .push_digit (div_rem),
        .top_digit  (top_digit)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done && !more_digits)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && (cnt_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = magnitude;
        push         = 1'b0;
        pop          = 1'b0;
        load_out     = 1'b0;
        load_char    = CHAR_MINUS;
        load_last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = s_axis_tvalid;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    push         = 1'b1;
                    div_start    = more_digits;
                    div_dividend = div_quot;
                end
            end
            ST_SIGN:
            begin
                load_out = slot_free;
            end
            ST_EMIT:
            begin
                load_out  = slot_free;
                pop       = slot_free;
                load_char = digit_char(top_digit);
                load_last = (cnt_reg == CNT_W'(1));
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_ready && s_axis_tvalid)
        begin
            cnt_next = '0;
        end
        else if (push)
        begin
            cnt_next = cnt_inc;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                radix_reg <= cfg_data;
            end
            if (in_ready && s_axis_tvalid)
            begin
                neg_reg <= s_axis_tdata[VALUE_W-1];
            end
        end
    end

    // Hold the beat while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_char_reg <= load_char;
            out_last_reg <= load_last;
        end
    end

    assign s_axis_tready = in_ready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[sv/sia_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, divisor is the radix.
module sia_divider
    import sia_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [RADIX_W-1:0] divisor,
    output logic               done,
    output logic [VALUE_W-1:0] quotient,
    output logic [DIGIT_W-1:0] remainder
);

    localparam int BIT_CNT_W = $clog2(VALUE_W);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [VALUE_W-1:0]   quot_reg;
    logic [VALUE_W-1:0]   quot_next;
    logic [DIGIT_W-1:0]   rem_reg;
    logic [DIGIT_W-1:0]   rem_next;
    logic [DIGIT_W:0]     partial;
    logic                 fits;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    assign partial = {rem_reg, quot_reg[VALUE_W-1]};
    assign fits    = partial >= {1'b0, divisor};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = '0;
            quot_next    = dividend;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            quot_next    = {quot_reg[VALUE_W-2:0], fits};
            rem_next     = fits ? DIGIT_W'(partial - {1'b0, divisor}) : DIGIT_W'(partial);
            bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
            if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

[sv/sia_digit_stack.sv]
// Shift-register digit stack: push least significant digit first, pop most significant first.
module sia_digit_stack
    import sia_pkg::*;
#(
    parameter int DEPTH = SIA_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               push,
    input  logic               pop,
    input  logic [DIGIT_W-1:0] push_digit,
    output logic [DIGIT_W-1:0] top_digit
);

    logic [DIGIT_W-1:0] stk_reg  [DEPTH];
    logic [DIGIT_W-1:0] stk_next [DEPTH];

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            stk_next[i] = stk_reg[i];
            if (push)
            begin
                stk_next[i] = (i == 0) ? push_digit : stk_reg[(i == 0) ? 0 : i - 1];
            end
            else if (pop && (i < DEPTH - 1))
            begin
                stk_next[i] = stk_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            stk_reg[i] <= stk_next[i];
        end
    end

    assign top_digit = stk_reg[0];

endmodule

[sv/sia_checker.sv]
// Port-level checker for the radix text converter, bound to the top level.
`include "signed_int_to_radix_ascii_unit_assert.svh"

module sia_checker
    import sia_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [VALUE_W-1:0] s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [CHAR_W-1:0]  m_axis_tdata,
    input logic               m_axis_tlast,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [RADIX_W-1:0] cfg_data
);

    logic ascii_ok;
    logic cfg_beat;

    assign ascii_ok = (m_axis_tdata == CHAR_MINUS)
                   || ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE))
                   || ((m_axis_tdata >= CHAR_LOWER_A) && (m_axis_tdata <= CHAR_LOWER_Z));
    assign cfg_beat = cfg_valid && cfg_ready && (cfg_data != '0 || s_axis_tdata != '0);

    `SIA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `SIA_ASSERT_IMPL(a_char_set, clk, rst_n, m_axis_tvalid, ascii_ok)
    `SIA_ASSERT_IMPL(a_sign_not_last, clk, rst_n, m_axis_tvalid && (m_axis_tdata == CHAR_MINUS), !m_axis_tlast)
    `SIA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SIA_ASSERT_IMPL(a_cfg_always_ready, clk, rst_n, cfg_beat || cfg_valid, cfg_ready)

endmodule

bind signed_int_to_radix_ascii_unit sia_checker u_sia_checker (.*);

[dv/sia_text_checker.sv]
// Checker for the radix text converter: predicts each value's characters and compares beats.
`timescale 1ns / 100ps

module sia_text_checker
    import sia_pkg::*;
#(
    parameter int MAX_DIGITS = SIA_MAX_DIGITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [CHAR_W-1:0]  m_axis_tdata,   // [7:0] character
    input  logic               m_axis_tlast,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data,       // [5:0] radix
    output int                 fail_count,
    output int                 pending_chars
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t         expected_text [$];
    logic [RADIX_W-1:0] active_radix;
    int                 mismatches;

    // Append the text of one value, most significant character first.
    function automatic void predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [VALUE_W-1:0] base;
        logic [DIGIT_W-1:0] digits [MAX_DIGITS];
        text_char_t         c;
        int                 n;
        if (active_radix < RADIX_MIN)
        begin
            base = VALUE_W'(RADIX_MIN);
        end
        else if (active_radix > RADIX_MAX)
        begin
            base = VALUE_W'(RADIX_MAX);
        end
        else
        begin
            base = VALUE_W'(active_radix);
        end
        magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
        n = 0;
        do
        begin
            digits[n] = DIGIT_W'(magnitude % base);
            magnitude = magnitude / base;
            n++;
        end
        while (magnitude != 0 && n < MAX_DIGITS);
        if (value[VALUE_W-1])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--)
        begin
            if (digits[k] >= DIGIT_TEN)
            begin
                c.code = CHAR_W'(digits[k]) + LETTER_OFFSET;
            end
            else
            begin
                c.code = CHAR_W'(digits[k]) + CHAR_ZERO;
            end
            c.last = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_text.delete();
            active_radix = RADIX_RESET;
            mismatches = 0;
            fail_count <= 0;
            pending_chars <= 0;
        end
        else
        begin
            // Check the output beat first: it can only belong to an older value.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character beat: got %h last %b",
                        m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    text_char_t want;
                    want = expected_text.pop_front();
                    if (m_axis_tdata !== want.code)
                    begin
                        $error("character mismatch: expected %h, got %h",
                            want.code, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last mismatch: expected %b, got %b",
                            want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                active_radix = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_text(s_axis_tdata);
            end
            fail_count <= mismatches;
            pending_chars <= expected_text.size();
        end
    end

endmodule

[dv/tb_signed_int_to_radix_ascii_unit.sv]
// Top of the radix text converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_signed_int_to_radix_ascii_unit;
    import sia_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 1200;
    localparam int PHASE_ITEMS   = 25;

    typedef enum {
        RX_OPEN,
        RX_CHOPPY,
        RX_SPARSE
    } rx_mode_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [VALUE_W-1:0] s_axis_tdata;   // [31:0] value
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [CHAR_W-1:0]  m_axis_tdata;   // [7:0] character
    logic               m_axis_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RADIX_W-1:0] cfg_data;       // [5:0] radix

    int                 fail_count;
    int                 pending_chars;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    bit                 hold_req = 1'b0;
    logic [RADIX_W-1:0] radix_setting = RADIX_RESET;

    always #HALF_PERIOD clk = ~clk;

    signed_int_to_radix_ascii_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    sia_text_checker text_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: switch between open, choppy and sparse stretches; hold off on request.
    initial
    begin
        rx_mode_t rx_mode;
        int       mode_left;
        int       pick;
        rx_mode = RX_OPEN;
        mode_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    pick = $urandom_range(0, 3);
                    rx_mode = (pick < 2) ? RX_OPEN : ((pick == 2) ? RX_CHOPPY : RX_SPARSE);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   m_axis_tready <= 1'b1;
                    RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one value; gaps come between bursts of random length.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every predicted character has come out.
    task automatic finish_phase();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_chars != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data <= RADIX_W'($urandom);
        radix_setting = r;
    endtask

    // Mix of full-range, small, extreme, digit-boundary and short values.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        longint unsigned    power;
        int unsigned        base;
        int                 steps;
        base = 32'(effective_radix(radix_setting));
        case ($urandom_range(0, 5))
            0, 1:
            begin
                v = $urandom;
            end
            2:
            begin
                v = int'($urandom_range(0, 200)) - 100;
            end
            3:
            begin
                v = $urandom_range(0, 1) ? (32'h8000_0000 + $urandom_range(0, 2))
                                         : (32'h7fff_ffff - $urandom_range(0, 2));
            end
            4:
            begin
                power = 64'd1;
                steps = $urandom_range(1, 31);
                for (int j = 0; j < steps; j++)
                begin
                    if (power * base <= 64'hffff_ffff)
                    begin
                        power = power * base;
                    end
                end
                v = VALUE_W'(power) - $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                begin
                    v = ~v + 1'b1;
                end
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                begin
                    v = ~v + 1'b1;
                end
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [RADIX_W-1:0] radix_plan [6];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default radix ten straight out of reset.
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hffff_ffff);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        finish_phase();

        // Largest radix: highest letter digit, extremes.
        set_radix(RADIX_MAX);
        send_value(32'd35);
        send_value(32'd1295);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        finish_phase();

        // Smallest radix: longest texts.
        set_radix(RADIX_MIN);
        send_value(32'd1);
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(32'h5555_5555);
        finish_phase();

        // Radix below two acts as two.
        set_radix(6'd0);
        send_value(-32'sd5);
        finish_phase();
        set_radix(6'd1);
        send_value(32'd3);
        finish_phase();

        // Radix above thirty-six acts as thirty-six.
        set_radix(6'd37);
        send_value(32'd36);
        finish_phase();
        set_radix(6'd63);
        send_value(32'd35);
        finish_phase();

        set_radix(6'd16);
        send_value(32'hdead_beef);
        send_value(32'hffff_fff0);
        finish_phase();

        radix_plan[0] = 6'd10;
        radix_plan[1] = RADIX_MIN;
        radix_plan[2] = RADIX_MAX;
        radix_plan[3] = 6'($urandom_range(3, 35));
        radix_plan[4] = 6'($urandom_range(0, 63));
        radix_plan[5] = 6'd16;
        for (int p = 0; p < 6; p++)
        begin
            set_radix(radix_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Stall the receiver long enough to back up into the input.
                if (p == 0 && i == 3)
                begin
                    hold_req = 1'b1;
                end
                send_value(random_value());
            end
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_chars == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
